@@ hw/rtl/trs_mmb_pkg.sv @@
// Types, constants and the operand selection for the TRS model matrix builder.
`timescale 1ns / 1ps

package trs_mmb_pkg;

	localparam int unsigned QW = 16;
	localparam int unsigned VW = 32;
	localparam int unsigned EW = 34;
	localparam int unsigned FRAC_SPLIT = 14;
	localparam int unsigned HW = EW - FRAC_SPLIT;
	localparam int unsigned PAW = HW + VW;
	localparam int unsigned PBW = FRAC_SPLIT + 1 + VW;
	localparam int unsigned PW = EW + VW;
	localparam int unsigned RW = PW - 28;

	localparam logic signed [EW-1:0] ONE_Q28 = EW'(64'sd268435456);
	localparam logic signed [PW-1:0] HALF_Q28 = PW'(64'sd134217728);
	localparam logic signed [VW-1:0] ROW3_ONE = 32'sd65536;
	localparam logic signed [VW-1:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [VW-1:0] SAT_MIN = 32'sh80000000;

	localparam logic [1:0] COL_X = 2'd0;
	localparam logic [1:0] COL_Y = 2'd1;
	localparam logic [1:0] COL_Z = 2'd2;
	localparam logic [1:0] COL_T = 2'd3;

	typedef struct packed {
		logic signed [VW-1:0] translation_x;
		logic signed [VW-1:0] translation_y;
		logic signed [VW-1:0] translation_z;
		logic signed [QW-1:0] quat_w;
		logic signed [QW-1:0] quat_x;
		logic signed [QW-1:0] quat_y;
		logic signed [QW-1:0] quat_z;
		logic signed [VW-1:0] scale_x;
		logic signed [VW-1:0] scale_y;
		logic signed [VW-1:0] scale_z;
	} item_t;

	typedef struct packed {
		logic [1:0]           column_index;
		logic signed [VW-1:0] row0_value;
		logic signed [VW-1:0] row1_value;
		logic signed [VW-1:0] row2_value;
		logic signed [VW-1:0] row3_value;
		logic                 last_column;
	} col_t;

	// One matrix element is base + 2 * (+/- a*b +/- c*d), times a multiplier.
	typedef struct packed {
		logic [QW-1:0] a;
		logic [QW-1:0] b;
		logic [QW-1:0] c;
		logic [QW-1:0] d;
		logic          neg_ab;
		logic          neg_cd;
		logic          base;
		logic [VW-1:0] mult;
	} elem_op_t;

	function automatic elem_op_t pick_op(item_t it, logic [1:0] col, int row);
		elem_op_t op;
		logic [QW-1:0] w, x, y, z;
		logic [VW-1:0] s;
		w = it.quat_w;
		x = it.quat_x;
		y = it.quat_y;
		z = it.quat_z;
		op = '0;
		case (col)
			COL_X: s = it.scale_x;
			COL_Y: s = it.scale_y;
			COL_Z: s = it.scale_z;
			default: s = '0;
		endcase
		op.mult = s;
		case (col)
			COL_X: begin
				case (row)
					0: op = '{y, y, z, z, 1'b1, 1'b1, 1'b1, s};
					1: op = '{x, y, w, z, 1'b0, 1'b0, 1'b0, s};
					default: op = '{x, z, w, y, 1'b0, 1'b1, 1'b0, s};
				endcase
			end
			COL_Y: begin
				case (row)
					0: op = '{x, y, w, z, 1'b0, 1'b1, 1'b0, s};
					1: op = '{x, x, z, z, 1'b1, 1'b1, 1'b1, s};
					default: op = '{y, z, w, x, 1'b0, 1'b0, 1'b0, s};
				endcase
			end
			COL_Z: begin
				case (row)
					0: op = '{x, z, w, y, 1'b0, 1'b0, 1'b0, s};
					1: op = '{y, z, w, x, 1'b0, 1'b1, 1'b0, s};
					default: op = '{x, x, y, y, 1'b1, 1'b1, 1'b1, s};
				endcase
			end
			default: begin
				// The translation passes through as 1.0 times the translation.
				op.base = 1'b1;
				case (row)
					0: op.mult = it.translation_x;
					1: op.mult = it.translation_y;
					default: op.mult = it.translation_z;
				endcase
			end
		endcase
		return op;
	endfunction

endpackage

@@ hw/rtl/trs_mmb_if.sv @@
// Handshake interfaces for the input word and the column word.
`timescale 1ns / 1ps

interface trs_mmb_item_if;
	logic                 valid;
	logic                 ready;
	trs_mmb_pkg::item_t   data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface trs_mmb_col_if;
	logic                 valid;
	logic                 ready;
	trs_mmb_pkg::col_t    data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/trs_mmb_row.sv @@
// One matrix row lane: element formation, scaled multiply, rounding and saturation.
`timescale 1ns / 1ps

module trs_mmb_row (
	input  logic                                  clk,
	input  logic                                  ce,
	input  trs_mmb_pkg::elem_op_t                 op,
	output logic signed [trs_mmb_pkg::VW-1:0]     value
);

	logic signed [2*trs_mmb_pkg::QW-1:0] p_ab_s2, p_cd_s2;
	logic                                neg_ab_s2, neg_cd_s2, base_s2;
	logic signed [trs_mmb_pkg::VW-1:0]   mult_s2, mult_s3;
	logic signed [trs_mmb_pkg::EW-1:0]   elem_s3;
	logic signed [trs_mmb_pkg::PAW-1:0]  pa_s4;
	logic signed [trs_mmb_pkg::PBW-1:0]  pb_s4;
	logic signed [trs_mmb_pkg::RW-1:0]   rnd_s5;
	logic signed [trs_mmb_pkg::VW-1:0]   value_s6;

	logic signed [trs_mmb_pkg::EW-1:0]   ab, cd, elem;
	logic signed [trs_mmb_pkg::HW-1:0]   hi;
	logic signed [trs_mmb_pkg::FRAC_SPLIT:0] lo;
	logic signed [trs_mmb_pkg::PW-1:0]   full;
	logic                                fits;

	always_comb begin
		ab = trs_mmb_pkg::EW'(p_ab_s2);
		cd = trs_mmb_pkg::EW'(p_cd_s2);
		if (neg_ab_s2) begin
			ab = -ab;
		end
		if (neg_cd_s2) begin
			cd = -cd;
		end
		elem = ((ab + cd) <<< 1) + (base_s2 ? trs_mmb_pkg::ONE_Q28 : '0);
	end

	assign hi = elem_s3[trs_mmb_pkg::EW-1:trs_mmb_pkg::FRAC_SPLIT];
	assign lo = $signed({1'b0, elem_s3[trs_mmb_pkg::FRAC_SPLIT-1:0]});

	assign full = (trs_mmb_pkg::PW'(pa_s4) <<< trs_mmb_pkg::FRAC_SPLIT)
		+ trs_mmb_pkg::PW'(pb_s4) + trs_mmb_pkg::HALF_Q28;

	assign fits = (rnd_s5[trs_mmb_pkg::RW-1:trs_mmb_pkg::VW-1] == '0)
		|| (rnd_s5[trs_mmb_pkg::RW-1:trs_mmb_pkg::VW-1] == '1);

	always_ff @(posedge clk) begin
		if (ce) begin
			p_ab_s2   <= $signed(op.a) * $signed(op.b);
			p_cd_s2   <= $signed(op.c) * $signed(op.d);
			neg_ab_s2 <= op.neg_ab;
			neg_cd_s2 <= op.neg_cd;
			base_s2   <= op.base;
			mult_s2   <= $signed(op.mult);
			elem_s3   <= elem;
			mult_s3   <= mult_s2;
			pa_s4     <= hi * mult_s3;
			pb_s4     <= lo * mult_s3;
			rnd_s5    <= full[trs_mmb_pkg::PW-1:28];
			if (fits) begin
				value_s6 <= rnd_s5[trs_mmb_pkg::VW-1:0];
			end else begin
				value_s6 <= rnd_s5[trs_mmb_pkg::RW-1] ? trs_mmb_pkg::SAT_MIN
					: trs_mmb_pkg::SAT_MAX;
			end
		end
	end

	assign value = value_s6;

endmodule

@@ hw/rtl/trs_model_matrix_builder.sv @@
// Top level of the TRS model matrix builder: column issue, pipeline control and row lanes.
//
//  Channel   Dir  Word                                          Per item
//  params    in   translation, quaternion, scale                one
//  columns   out  column index, four row values, last flag      four
//
// An input word is held while its four columns issue, one per cycle unless columns stalls,
// into a six-stage pipeline; a new word is taken in the cycle its last column issues.
// The sustained input rate is set by the column issue.
// After acceptance, the first column passes the held input word, then stages s1 to s6.
// A stall on columns freezes every stage at once; nothing is dropped or repeated.
// Reset clears only the valid bits and the column counter.
`timescale 1ns / 1ps

module trs_model_matrix_builder (
	input  logic                  clk,
	input  logic                  arst_n,
	trs_mmb_item_if.sink          params,
	trs_mmb_col_if.source         columns
);

	localparam int unsigned NROW = 3;
	localparam int unsigned NST = 6;

	trs_mmb_pkg::item_t     item_q;
	logic                   hold_v_q;
	logic [1:0]             col_q;
	trs_mmb_pkg::elem_op_t  op_s1 [NROW];
	logic [NST-1:0]         v_q;
	logic [1:0]             col_pipe_q [NST];
	logic signed [trs_mmb_pkg::VW-1:0] row_val [NROW];
	logic                   ce;
	logic                   take;

	assign ce = !v_q[NST-1] || columns.ready;
	assign params.ready = !hold_v_q || (ce && col_q == trs_mmb_pkg::COL_T);
	assign take = params.valid && params.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			col_q    <= trs_mmb_pkg::COL_X;
			v_q      <= '0;
		end else begin
			if (take) begin
				hold_v_q <= 1'b1;
				col_q    <= trs_mmb_pkg::COL_X;
			end else if (ce && hold_v_q) begin
				col_q <= col_q + 2'd1;
				if (col_q == trs_mmb_pkg::COL_T) begin
					hold_v_q <= 1'b0;
				end
			end
			if (ce) begin
				v_q <= {v_q[NST-2:0], hold_v_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= params.data;
		end
		if (ce) begin
			col_pipe_q[0] <= col_q;
			for (int i = 1; i < NST; i++) begin
				col_pipe_q[i] <= col_pipe_q[i-1];
			end
			for (int r = 0; r < NROW; r++) begin
				op_s1[r] <= trs_mmb_pkg::pick_op(item_q, col_q, r);
			end
		end
	end

	for (genvar r = 0; r < NROW; r++) begin : g_row
		trs_mmb_row u_row (
			.clk   (clk),
			.ce    (ce),
			.op    (op_s1[r]),
			.value (row_val[r])
		);
	end

	assign columns.valid = v_q[NST-1];
	assign columns.data.column_index = col_pipe_q[NST-1];
	assign columns.data.row0_value = row_val[0];
	assign columns.data.row1_value = row_val[1];
	assign columns.data.row2_value = row_val[2];
	assign columns.data.row3_value = (col_pipe_q[NST-1] == trs_mmb_pkg::COL_T)
		? trs_mmb_pkg::ROW3_ONE : '0;
	assign columns.data.last_column = (col_pipe_q[NST-1] == trs_mmb_pkg::COL_T);

endmodule

@@ hw/rtl/trs_mmb_checker.sv @@
// Port-level checks on the column channel of the TRS model matrix builder.
`timescale 1ns / 1ps

module trs_mmb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input trs_mmb_pkg::col_t  out_data
);

	logic [1:0] exp_col_q;
	logic       acc;

	assign acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_col_q <= trs_mmb_pkg::COL_X;
		end else if (acc) begin
			exp_col_q <= exp_col_q + 2'd1;
		end
	end

	a_col_order: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> out_data.column_index == exp_col_q)
		else $error("column words out of order");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> out_data.last_column == (out_data.column_index == trs_mmb_pkg::COL_T))
		else $error("last flag does not match column index");

	a_row3: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (out_data.column_index == trs_mmb_pkg::COL_T
			&& out_data.row3_value == trs_mmb_pkg::ROW3_ONE)
			|| (out_data.column_index != trs_mmb_pkg::COL_T && out_data.row3_value == '0))
		else $error("bottom row value is wrong");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled column word changed");

endmodule

bind trs_model_matrix_builder trs_mmb_checker u_trs_mmb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (columns.valid),
	.out_ready (columns.ready),
	.out_data  (columns.data)
);
